>>> rtl/core/bck_pkg.sv
// Shared widths, codes and helper functions for the two-cable bipod kinematics core.
// Used by bck_div_pipe, bck_sqrt_pipe and bipod_cable_kinematics_top.
package bck_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int REG_WIDTH      = VALUE_WIDTH - 1;
    localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
    localparam int NUM_WIDTH      = 2 * VALUE_WIDTH;
    localparam int DEN_WIDTH      = VALUE_WIDTH;
    localparam int QUO_WIDTH      = VALUE_WIDTH + 1;
    localparam int DIV_LAT        = QUO_WIDTH + 1;
    localparam int XW             = VALUE_WIDTH + 2;
    localparam int SUM_WIDTH      = VALUE_WIDTH + 3;
    localparam int ROOT_WIDTH     = VALUE_WIDTH + 2;
    localparam int RAD_WIDTH      = 2 * ROOT_WIDTH;
    localparam int SQ_LAT         = ROOT_WIDTH + 1;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int DATA_WIDTH     = 2 * VALUE_WIDTH;

    localparam logic [REG_WIDTH-1:0] LENGTH_RESET = REG_WIDTH'(1000) << FRACTION_BITS;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ANCHOR_DISTANCE    = 3'd0,
        CFG_HOME_LENGTH_FIRST  = 3'd1,
        CFG_HOME_LENGTH_SECOND = 3'd2,
        CFG_REFERENCE_X        = 3'd3,
        CFG_REFERENCE_Y        = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_FORWARD = 1'b0,
        OP_INVERSE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNREACH  = 2'd1,
        STATUS_HOME_BAD = 2'd2
    } status_t;

    function automatic logic [VALUE_WIDTH-1:0] sat_signed(input logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] hi;
        logic signed [SUM_WIDTH-1:0] lo;
        hi = $signed(SUM_WIDTH'({1'b0, {(VALUE_WIDTH-1){1'b1}}}));
        lo = -hi - SUM_WIDTH'(1);
        if (v > hi) begin
            return hi[VALUE_WIDTH-1:0];
        end else if (v < lo) begin
            return lo[VALUE_WIDTH-1:0];
        end
        return v[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] sat_root(input logic [ROOT_WIDTH:0] r);
        logic [ROOT_WIDTH:0] hi;
        hi = (ROOT_WIDTH+1)'({(VALUE_WIDTH-1){1'b1}});
        if (r > hi) begin
            return hi[VALUE_WIDTH-1:0];
        end
        return r[VALUE_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/bck_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
// Depends on bck_pkg for widths.
module bck_div_pipe (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [bck_pkg::NUM_WIDTH-1:0] num,
    input  logic [bck_pkg::DEN_WIDTH-1:0] den,
    output logic [bck_pkg::QUO_WIDTH-1:0] quo,
    output logic                          ovf
);
    localparam int NW = bck_pkg::NUM_WIDTH;
    localparam int DW = bck_pkg::DEN_WIDTH;
    localparam int QW = bck_pkg::QUO_WIDTH;

    logic [DW-1:0] rem_reg  [QW+1];
    logic [DW-1:0] rem_next [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [QW-1:0] low_next [QW+1];
    logic [QW-1:0] quo_reg  [QW+1];
    logic [QW-1:0] quo_next [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [DW-1:0] den_next [QW+1];
    logic          ovf_reg  [QW+1];
    logic          ovf_next [QW+1];
    logic [DW:0]   trial    [QW+1];
    logic          ovf_in;

    always_comb begin
        ovf_in      = DW'(num[NW-1:QW]) >= den;
        rem_next[0] = ovf_in ? '0 : DW'(num[NW-1:QW]);
        low_next[0] = num[QW-1:0];
        quo_next[0] = '0;
        den_next[0] = den;
        ovf_next[0] = ovf_in;
        trial[0]    = '0;
        for (int k = 1; k <= QW; k++) begin
            trial[k]    = {rem_reg[k-1], low_reg[k-1][QW-1]};
            den_next[k] = den_reg[k-1];
            ovf_next[k] = ovf_reg[k-1];
            low_next[k] = {low_reg[k-1][QW-2:0], 1'b0};
            if (trial[k] >= {1'b0, den_reg[k-1]}) begin
                rem_next[k] = DW'(trial[k] - {1'b0, den_reg[k-1]});
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[k][DW-1:0];
                quo_next[k] = {quo_reg[k-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QW; k++) begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
                ovf_reg[k] <= ovf_next[k];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

>>> rtl/core/bck_sqrt_pipe.sv
// Pipelined digit-by-digit square root, one root bit per stage, rounded to nearest.
// Depends on bck_pkg for widths.
module bck_sqrt_pipe (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [bck_pkg::RAD_WIDTH-1:0]  rad,
    output logic [bck_pkg::ROOT_WIDTH:0]   root
);
    localparam int RW = bck_pkg::ROOT_WIDTH;
    localparam int AW = bck_pkg::RAD_WIDTH;

    logic [RW:0]   rem_reg   [RW];
    logic [RW:0]   rem_next  [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [RW-1:0] root_next [RW];
    logic [AW-1:0] bits_reg  [RW];
    logic [AW-1:0] bits_next [RW];
    logic [RW+2:0] shifted   [RW];
    logic [RW+2:0] trial     [RW];
    logic [RW:0]   rem_prev  [RW];
    logic [RW-1:0] root_prev [RW];
    logic [AW-1:0] bits_prev [RW];
    logic [RW:0]   round_reg;

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                rem_prev[k]  = '0;
                root_prev[k] = '0;
                bits_prev[k] = rad;
            end else begin
                rem_prev[k]  = rem_reg[k-1];
                root_prev[k] = root_reg[k-1];
                bits_prev[k] = bits_reg[k-1];
            end
            shifted[k]   = {rem_prev[k], bits_prev[k][AW-1:AW-2]};
            trial[k]     = (RW+3)'({root_prev[k], 2'b01});
            bits_next[k] = {bits_prev[k][AW-3:0], 2'b00};
            if (shifted[k] >= trial[k]) begin
                rem_next[k]  = (RW+1)'(shifted[k] - trial[k]);
                root_next[k] = {root_prev[k][RW-2:0], 1'b1};
            end else begin
                rem_next[k]  = shifted[k][RW:0];
                root_next[k] = {root_prev[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < RW; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                bits_reg[k] <= bits_next[k];
            end
            round_reg <= {1'b0, root_reg[RW-1]}
                       + (RW+1)'(rem_reg[RW-1] > {1'b0, root_reg[RW-1]});
        end
    end

    assign root = round_reg;

endmodule

>>> rtl/core/bipod_cable_kinematics_top.sv
// Two-cable bipod forward and inverse kinematics, fully pipelined streaming core.
// The divider and the two square root pipelines lie in series; one transaction is
// accepted per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline. Reset is synchronous, active low, clears
// all valid bits and loads the configuration registers with their default values.
// Depends on bck_pkg, bck_div_pipe and bck_sqrt_pipe.
module bipod_cable_kinematics_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bck_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [bck_pkg::VALUE_WIDTH-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bck_pkg::DATA_WIDTH-1:0]      s_tdata,   // operand_a, operand_b
    input  logic                                s_tuser,   // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bck_pkg::DATA_WIDTH-1:0]      m_tdata,   // result_a, result_b
    output logic [1:0]                          m_tuser    // status
);
    localparam int VW   = bck_pkg::VALUE_WIDTH;
    localparam int RGW  = bck_pkg::REG_WIDTH;
    localparam int PW   = bck_pkg::PROD_WIDTH;
    localparam int NW   = bck_pkg::NUM_WIDTH;
    localparam int QW   = bck_pkg::QUO_WIDTH;
    localparam int XW   = bck_pkg::XW;
    localparam int SW   = bck_pkg::SUM_WIDTH;
    localparam int RW   = bck_pkg::ROOT_WIDTH;
    localparam int AW   = bck_pkg::RAD_WIDTH;
    localparam int DLAT = bck_pkg::DIV_LAT;
    localparam int SLAT = bck_pkg::SQ_LAT;

    typedef struct packed {
        logic                  op;
        logic signed [VW-1:0]  a;
        logic signed [VW-1:0]  b;
        logic                  neg0;
        logic                  neg1;
    } div_sb_t;

    typedef struct packed {
        logic                  op;
        logic signed [VW-1:0]  a;
        logic signed [VW-1:0]  b;
        logic signed [XW-1:0]  x0;
        logic signed [XW-1:0]  x1;
        logic                  bad;
        logic                  unr;
    } sq1_sb_t;

    typedef struct packed {
        logic                  op;
        logic                  bad;
        logic                  unr;
        logic [VW-1:0]         fwd_a;
        logic [VW-1:0]         fwd_b;
    } sq2_sb_t;

    logic [RGW-1:0]        anchor_distance_reg;
    logic [RGW-1:0]        home_length_first_reg;
    logic [RGW-1:0]        home_length_second_reg;
    logic signed [VW-1:0]  reference_x_reg;
    logic signed [VW-1:0]  reference_y_reg;

    logic                  adv;
    logic                  m_tvalid_reg;
    logic [2*VW-1:0]       m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    logic [PW-1:0]         dd_p, h0sq_p, h1sq_p;

    logic                  op1_reg;
    logic signed [VW-1:0]  a1_reg, b1_reg;
    logic [PW-1:0]         dd1_reg, h0sq1_reg, h1sq1_reg, asq1_reg, bsq1_reg;

    div_sb_t               s2_reg;
    logic [NW-1:0]         num0_reg, num1_reg;
    logic [NW:0]           n0, n1, n0_abs, n1_abs;

    logic [DLAT-1:0]       div_v_reg;
    div_sb_t               div_sb_reg [DLAT];
    logic [QW-1:0]         quo0, quo1;
    logic                  ovf0, ovf1;

    sq1_sb_t               s3_reg;
    logic [VW:0]           a_ext, abs_a;

    sq1_sb_t               s4_reg;
    logic [AW-1:0]         h0sq4_reg, x0sq4_reg, asq4_reg, x1sq4_reg;
    logic [AW:0]           y0_diff, s_diff;

    sq1_sb_t               s5_reg;
    logic [AW-1:0]         rad_y0_reg, rad_s_reg;

    logic [SLAT-1:0]       sq1_v_reg;
    sq1_sb_t               sq1_sb_reg [SLAT];
    logic [RW:0]           root_y0, root_s;

    sq2_sb_t               s6_reg;
    logic signed [SW-1:0]  x3_reg, y3_reg, dx_reg;
    logic signed [SW-1:0]  d_s, y0_s, s_s, x0_s, x1_s, a_s, b_s, rx_s, ry_s;

    sq2_sb_t               s7_reg;
    logic [AW-1:0]         x3sq_reg, y3sq_reg, dxsq_reg;
    logic signed [2*SW-1:0] x3sq, y3sq, dxsq;

    sq2_sb_t               s8_reg;
    logic [AW-1:0]         rad_l1_reg, rad_l2_reg;

    logic [SLAT-1:0]       sq2_v_reg;
    sq2_sb_t               sq2_sb_reg [SLAT];
    logic [RW:0]           root_l1, root_l2;
    sq2_sb_t               fin;

    logic signed [2*VW-1:0] asq_s, bsq_s;
    logic signed [2*XW-1:0] x0sq_s, x1sq_s, asq4_s;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_distance_reg    <= bck_pkg::LENGTH_RESET;
            home_length_first_reg  <= bck_pkg::LENGTH_RESET;
            home_length_second_reg <= bck_pkg::LENGTH_RESET;
            reference_x_reg        <= '0;
            reference_y_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (bck_pkg::cfg_index_t'(cfg_index))
                bck_pkg::CFG_ANCHOR_DISTANCE:    anchor_distance_reg    <= cfg_data[RGW-1:0];
                bck_pkg::CFG_HOME_LENGTH_FIRST:  home_length_first_reg  <= cfg_data[RGW-1:0];
                bck_pkg::CFG_HOME_LENGTH_SECOND: home_length_second_reg <= cfg_data[RGW-1:0];
                bck_pkg::CFG_REFERENCE_X:        reference_x_reg        <= cfg_data;
                bck_pkg::CFG_REFERENCE_Y:        reference_y_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: squares of the configuration and the operands.
    assign dd_p   = anchor_distance_reg * anchor_distance_reg;
    assign h0sq_p = home_length_first_reg * home_length_first_reg;
    assign h1sq_p = home_length_second_reg * home_length_second_reg;
    assign asq_s  = $signed(s_tdata[VW-1:0]) * $signed(s_tdata[VW-1:0]);
    assign bsq_s  = $signed(s_tdata[2*VW-1:VW]) * $signed(s_tdata[2*VW-1:VW]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg   <= s_tuser;
            a1_reg    <= s_tdata[VW-1:0];
            b1_reg    <= s_tdata[2*VW-1:VW];
            dd1_reg   <= dd_p;
            h0sq1_reg <= h0sq_p;
            h1sq1_reg <= h1sq_p;
            asq1_reg  <= asq_s;
            bsq1_reg  <= bsq_s;
        end
    end

    // Stage 2: dividend magnitudes with the half-divisor added for rounding.
    always_comb begin
        n0     = {1'b0, dd1_reg} + {1'b0, h0sq1_reg} - {1'b0, h1sq1_reg};
        n1     = {1'b0, asq1_reg} - {1'b0, bsq1_reg} + {1'b0, dd1_reg};
        n0_abs = n0[NW] ? (~n0 + 1'b1) : n0;
        n1_abs = n1[NW] ? (~n1 + 1'b1) : n1;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg.op   <= op1_reg;
            s2_reg.a    <= a1_reg;
            s2_reg.b    <= b1_reg;
            s2_reg.neg0 <= n0[NW];
            s2_reg.neg1 <= n1[NW];
            num0_reg    <= n0_abs[NW-1:0] + NW'(anchor_distance_reg);
            num1_reg    <= n1_abs[NW-1:0] + NW'(anchor_distance_reg);
        end
    end

    bck_div_pipe u_div_home (
        .aclk (aclk),
        .en   (adv),
        .num  (num0_reg),
        .den  ({anchor_distance_reg, 1'b0}),
        .quo  (quo0),
        .ovf  (ovf0)
    );

    bck_div_pipe u_div_fwd (
        .aclk (aclk),
        .en   (adv),
        .num  (num1_reg),
        .den  ({anchor_distance_reg, 1'b0}),
        .quo  (quo1),
        .ovf  (ovf1)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_sb_reg[0] <= s2_reg;
            for (int i = 1; i < DLAT; i++) begin
                div_sb_reg[i] <= div_sb_reg[i-1];
            end
        end
    end

    // Stage 3: signed quotients and the reachability checks.
    always_comb begin
        a_ext = {div_sb_reg[DLAT-1].a[VW-1], div_sb_reg[DLAT-1].a};
        abs_a = a_ext[VW] ? (~a_ext + 1'b1) : a_ext;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg.op  <= div_sb_reg[DLAT-1].op;
            s3_reg.a   <= div_sb_reg[DLAT-1].a;
            s3_reg.b   <= div_sb_reg[DLAT-1].b;
            s3_reg.x0  <= div_sb_reg[DLAT-1].neg0 ? -$signed({1'b0, quo0}) : $signed({1'b0, quo0});
            s3_reg.x1  <= div_sb_reg[DLAT-1].neg1 ? -$signed({1'b0, quo1}) : $signed({1'b0, quo1});
            s3_reg.bad <= (anchor_distance_reg == '0) || ovf0
                          || (quo0 > QW'(home_length_first_reg));
            s3_reg.unr <= ovf1 || (quo1 > abs_a);
        end
    end

    // Stage 4: squares for the two square root radicands.
    assign x0sq_s = s3_reg.x0 * s3_reg.x0;
    assign x1sq_s = s3_reg.x1 * s3_reg.x1;
    assign asq4_s = XW'(s3_reg.a) * XW'(s3_reg.a);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_reg    <= s3_reg;
            h0sq4_reg <= AW'(h0sq_p);
            x0sq4_reg <= x0sq_s[AW-1:0];
            asq4_reg  <= asq4_s[AW-1:0];
            x1sq4_reg <= x1sq_s[AW-1:0];
        end
    end

    // Stage 5: radicands, held at zero when the circles do not meet.
    always_comb begin
        y0_diff = {1'b0, h0sq4_reg} - {1'b0, x0sq4_reg};
        s_diff  = {1'b0, asq4_reg} - {1'b0, x1sq4_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_reg     <= s4_reg;
            rad_y0_reg <= y0_diff[AW] ? '0 : y0_diff[AW-1:0];
            rad_s_reg  <= s_diff[AW] ? '0 : s_diff[AW-1:0];
        end
    end

    bck_sqrt_pipe u_sqrt_y0 (
        .aclk (aclk),
        .en   (adv),
        .rad  (rad_y0_reg),
        .root (root_y0)
    );

    bck_sqrt_pipe u_sqrt_fwd (
        .aclk (aclk),
        .en   (adv),
        .rad  (rad_s_reg),
        .root (root_s)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_sb_reg[0] <= s5_reg;
            for (int i = 1; i < SLAT; i++) begin
                sq1_sb_reg[i] <= sq1_sb_reg[i-1];
            end
        end
    end

    // Stage 6: forward results and the inverse offsets.
    always_comb begin
        d_s  = $signed(SW'(anchor_distance_reg));
        y0_s = $signed({1'b0, root_y0[SW-2:0]});
        s_s  = $signed({1'b0, root_s[SW-2:0]});
        x0_s = SW'(sq1_sb_reg[SLAT-1].x0);
        x1_s = SW'(sq1_sb_reg[SLAT-1].x1);
        a_s  = SW'(sq1_sb_reg[SLAT-1].a);
        b_s  = SW'(sq1_sb_reg[SLAT-1].b);
        rx_s = SW'(reference_x_reg);
        ry_s = SW'(reference_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_reg.op    <= sq1_sb_reg[SLAT-1].op;
            s6_reg.bad   <= sq1_sb_reg[SLAT-1].bad;
            s6_reg.unr   <= sq1_sb_reg[SLAT-1].unr;
            s6_reg.fwd_a <= bck_pkg::sat_signed(x1_s - x0_s + rx_s);
            s6_reg.fwd_b <= bck_pkg::sat_signed(y0_s - s_s + ry_s);
            x3_reg       <= x0_s + a_s - rx_s;
            y3_reg       <= y0_s - b_s + ry_s;
            dx_reg       <= d_s - x0_s - a_s + rx_s;
        end
    end

    // Stage 7: squares of the inverse offsets.
    assign x3sq = x3_reg * x3_reg;
    assign y3sq = y3_reg * y3_reg;
    assign dxsq = dx_reg * dx_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_reg   <= s6_reg;
            x3sq_reg <= x3sq[AW-1:0];
            y3sq_reg <= y3sq[AW-1:0];
            dxsq_reg <= dxsq[AW-1:0];
        end
    end

    // Stage 8: cable length radicands.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_reg     <= s7_reg;
            rad_l1_reg <= x3sq_reg + y3sq_reg;
            rad_l2_reg <= dxsq_reg + y3sq_reg;
        end
    end

    bck_sqrt_pipe u_sqrt_l1 (
        .aclk (aclk),
        .en   (adv),
        .rad  (rad_l1_reg),
        .root (root_l1)
    );

    bck_sqrt_pipe u_sqrt_l2 (
        .aclk (aclk),
        .en   (adv),
        .rad  (rad_l2_reg),
        .root (root_l2)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq2_sb_reg[0] <= s8_reg;
            for (int i = 1; i < SLAT; i++) begin
                sq2_sb_reg[i] <= sq2_sb_reg[i-1];
            end
        end
    end

    assign fin = sq2_sb_reg[SLAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            div_v_reg    <= '0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            sq1_v_reg    <= '0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            sq2_v_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            div_v_reg    <= {div_v_reg[DLAT-2:0], v2_reg};
            v3_reg       <= div_v_reg[DLAT-1];
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            sq1_v_reg    <= {sq1_v_reg[SLAT-2:0], v5_reg};
            v6_reg       <= sq1_v_reg[SLAT-1];
            v7_reg       <= v6_reg;
            v8_reg       <= v7_reg;
            sq2_v_reg    <= {sq2_v_reg[SLAT-2:0], v8_reg};
            m_tvalid_reg <= sq2_v_reg[SLAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (fin.bad) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= bck_pkg::STATUS_HOME_BAD;
            end else if (fin.op == bck_pkg::OP_INVERSE) begin
                m_tdata_reg <= {bck_pkg::sat_root(root_l2), bck_pkg::sat_root(root_l1)};
                m_tuser_reg <= bck_pkg::STATUS_OK;
            end else if (fin.unr) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= bck_pkg::STATUS_UNREACH;
            end else begin
                m_tdata_reg <= {fin.fwd_b, fin.fwd_a};
                m_tuser_reg <= bck_pkg::STATUS_OK;
            end
        end
    end

    // A result with a bad home geometry or an unreachable position carries zero data.
    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bck_pkg::STATUS_HOME_BAD || m_tuser == bck_pkg::STATUS_UNREACH)
        |-> m_tdata == '0)
        else $error("error status with nonzero data");

    // A stalled output must hold back the input side.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input ready while output stalled");

    // A stalled transaction keeps its result.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Nothing leaves the pipeline right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
